// ----- design/sli_pkg.sv -----
package sli_pkg;

    localparam int CAPACITY = 16;
    localparam int VALUE_W  = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int COUNT_W  = 5;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Broadcast control from the top level to every cell
    typedef struct packed {
        logic is_insert;
        logic ins_en;
        logic del_en;
    } cell_cmd_t;

endpackage

// ----- design/sli_cell.sv -----
module sli_cell
    import sli_pkg::*;
(
    input  logic                      clk,
    input  cell_cmd_t                 cmd,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      occupied,
    input  logic                      prev_mark,
    input  logic signed [VALUE_W-1:0] left_entry,
    input  logic signed [VALUE_W-1:0] right_entry,
    output logic signed [VALUE_W-1:0] entry,
    output logic                      mark,
    output logic                      first_hit
);

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;
    logic                      ge;

    // Mark covers this slot and all slots to its right that move
    assign ge        = occupied && (entry_reg >= value);
    assign mark      = ge || (cmd.is_insert && !occupied);
    assign first_hit = occupied && (entry_reg == value) && !prev_mark;
    assign entry     = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (cmd.ins_en && mark && prev_mark)
        begin
            entry_next = left_entry;
        end
        else if (cmd.ins_en && mark)
        begin
            entry_next = value;
        end
        else if (cmd.del_en && mark)
        begin
            entry_next = right_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    // Payload only: no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- design/sorted_list_insert_delete.sv -----
// Sorted store of up to CAPACITY signed 32-bit values, kept in ascending order
// with duplicates allowed. Each input word either inserts its value (mode 0)
// ahead of the first stored value that is not smaller, or deletes one
// occurrence of it (mode 1). Each accepted word returns exactly one output
// word with a status (done, not found, empty, full) and the fill count after
// the operation. The store is a row of cells, one per slot; every cell
// compares its value against the incoming one and, in the same cycle, either
// holds, loads the new value, or takes its left or right neighbor's value.
// The whole insert or delete completes at the accepting clock edge, so the
// block takes one word per cycle whenever its output word is taken; its speed
// is set by one 32-bit compare in each cell plus the found-OR across the row.
// The input stalls only while an output word waits and the output is stalled.
// No clearing pass is needed after reset: values in slots at or above the fill
// count never reach an occupied slot or the output.
module sorted_list_insert_delete
    import sli_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      mode,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                status,
    output logic [COUNT_W-1:0]        entry_count
);

    logic [CNT_W-1:0]          fill_reg;
    logic [CNT_W-1:0]          fill_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    status_t                   status_reg;
    status_t                   status_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;

    logic                      accept;
    logic                      is_full;
    logic                      is_empty;
    logic                      found;
    cell_cmd_t                 cmd;

    logic signed [VALUE_W-1:0] entries [CAPACITY];
    logic [CAPACITY-1:0]       marks;
    logic [CAPACITY-1:0]       hits;

    // Hold input while a finished word is waiting and the sink stalls
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign is_full  = (fill_reg == CNT_W'(CAPACITY));
    assign is_empty = (fill_reg == '0);
    assign found    = |hits;

    assign cmd.is_insert = (mode == MODE_INSERT);
    assign cmd.ins_en    = accept && (mode == MODE_INSERT) && !is_full;
    assign cmd.del_en    = accept && (mode == MODE_DELETE) && found;

    // Row of cells; the first cell sees a zero mark, and each end of the row sees its own value
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                      prev_mark;
        logic signed [VALUE_W-1:0] left_entry;
        logic signed [VALUE_W-1:0] right_entry;

        if (i == 0)
        begin : g_first
            assign prev_mark  = 1'b0;
            assign left_entry = entries[i];
        end
        else
        begin : g_mid_l
            assign prev_mark  = marks[i-1];
            assign left_entry = entries[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_entry = entries[i];
        end
        else
        begin : g_mid_r
            assign right_entry = entries[i+1];
        end

        sli_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .value       (value),
            .occupied    (fill_reg > CNT_W'(i)),
            .prev_mark   (prev_mark),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entries[i]),
            .mark        (marks[i]),
            .first_hit   (hits[i])
        );
    end

    // Status, fill update and output word
    always_comb
    begin
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        count_next     = count_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            unique case (mode)
                MODE_INSERT:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        status_next = ST_DONE;
                        fill_next   = fill_reg + CNT_W'(1);
                    end
                end
                MODE_DELETE:
                begin
                    priority if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else if (!found)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    else
                    begin
                        status_next = ST_DONE;
                        fill_next   = fill_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = status_reg;
                end
            endcase
            count_next = fill_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        count_reg  <= count_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_count = COUNT_W'(count_reg);

endmodule

// ----- design/sli_checker.sv -----
module sli_checker
    import sli_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic [1:0]                status,
    input  logic [COUNT_W-1:0]        entry_count
);

    // Stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(entry_count))
        else $error("output word changed while stalled");

    // Accepted word yields an output word next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted word produced no output word");

    // Full report carries the full count
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> entry_count == COUNT_W'(CAPACITY))
        else $error("full status with wrong count");

    // Empty report carries a zero count; not-found a nonzero count
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> entry_count == '0)
        else $error("empty status with nonzero count");

    a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NOT_FOUND) |-> entry_count != '0)
        else $error("not-found status on an empty store");

endmodule

bind sorted_list_insert_delete sli_checker u_sli_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .entry_count (entry_count)
);
